@@ rtl/wht_pkg.sv @@
// ----------------------------------------------------------------------------
// Waypoint heading tracker package
// Shared constants, register indexes, sequencer states and the CORDIC table.
// ----------------------------------------------------------------------------
package wht_pkg;

   localparam int MAX_POINTS_DEF    = 256;
   localparam int SEARCH_WINDOW_DEF = 16;

   localparam int LOOKAHEAD    = 3;
   localparam int CORDIC_STEPS = 13;
   localparam int PI_Q12       = 12868;
   localparam int TWO_PI_Q12   = 25736;
   localparam int DEG_HALF     = 180;
   localparam int DIV_STEPS    = 30;

   localparam logic [1:0] CSR_TARGET_SPEED = 2'd0;
   localparam logic [1:0] CSR_ANGLE_TOL    = 2'd1;
   localparam logic [1:0] CSR_POINT_COUNT  = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_POSE = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SCAN,
      S_DIFF,
      S_SQX,
      S_SQY,
      S_CMP,
      S_CHECK,
      S_RDA,
      S_RDB,
      S_CORD,
      S_WRAP,
      S_SPEED,
      S_NUM,
      S_DEN,
      S_DIVS,
      S_DIV,
      S_EMIT
   } state_type;

   function automatic logic signed [15:0] atan_q12(input logic [3:0] step);
      logic signed [15:0] v;
      case (step)
         4'd0:    v = 16'sd3217;
         4'd1:    v = 16'sd1899;
         4'd2:    v = 16'sd1003;
         4'd3:    v = 16'sd509;
         4'd4:    v = 16'sd256;
         4'd5:    v = 16'sd128;
         4'd6:    v = 16'sd64;
         4'd7:    v = 16'sd32;
         4'd8:    v = 16'sd16;
         4'd9:    v = 16'sd8;
         4'd10:   v = 16'sd4;
         4'd11:   v = 16'sd2;
         4'd12:   v = 16'sd1;
         default: v = 16'sd0;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/wht_path_mem.sv @@
// ----------------------------------------------------------------------------
// Waypoint path memory
// One write port and one registered read port holding {y, x} per waypoint.
// ----------------------------------------------------------------------------
module wht_path_mem #(
   parameter int MAX_POINTS = wht_pkg::MAX_POINTS_DEF,
   localparam int AW = $clog2(MAX_POINTS)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data
);

   logic [63:0] mem_ff [MAX_POINTS];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/wht_cordic.sv @@
// ----------------------------------------------------------------------------
// Iterative CORDIC arctangent
// Vectoring mode atan2 with quadrant pre-rotation, one step per cycle.
// ----------------------------------------------------------------------------
module wht_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] vec_x,
   input  logic signed [32:0] vec_y,
   output logic               done,
   output logic signed [15:0] angle
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [3:0]         step_ff, step_in;
   logic signed [35:0] x_ff, x_in;
   logic signed [35:0] y_ff, y_in;
   logic signed [15:0] z_ff, z_in;
   logic signed [35:0] xs, ys, sx, sy;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      sx      = 36'(vec_x);
      sy      = 36'(vec_y);
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      if (start) begin
         step_in = 4'd0;
         x_in    = sx;
         y_in    = sy;
         z_in    = 16'sd0;
         if (vec_x == 33'sd0 && vec_y == 33'sd0) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            if (vec_x < 0) begin
               z_in = (vec_y >= 0) ? 16'(wht_pkg::PI_Q12) : -16'(wht_pkg::PI_Q12);
               x_in = -sx;
               y_in = -sy;
            end
         end
      end else if (busy_ff) begin
         if (y_ff < 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - wht_pkg::atan_q12(step_ff);
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + wht_pkg::atan_q12(step_ff);
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(wht_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule

@@ rtl/wht_divider.sv @@
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Unsigned division producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wht_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [29:0] dividend,
   input  logic [21:0] divisor,
   output logic        done,
   output logic [29:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [22:0] rem_ff, rem_in;
   logic [29:0] quo_ff, quo_in;
   logic [21:0] div_ff, div_in;
   logic [22:0] rem_sh;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      rem_sh   = {rem_ff[21:0], quo_ff[29]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = 5'd0;
         rem_in   = 23'd0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[28:0], 1'b0};
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in    = rem_sh - {1'b0, div_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = rem_sh;
         end
         count_in = count_ff + 5'd1;
         if (count_ff == 5'(wht_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/waypoint_heading_tracker_top.sv @@
// ----------------------------------------------------------------------------
// Waypoint heading tracker
// Nearest-waypoint search and heading steering for a differential drive.
// ----------------------------------------------------------------------------
// A request with cmd 0 writes one waypoint into the path memory if its index
// is below MAX_POINTS and produces no response. A request with cmd 1 is a pose
// sample and produces exactly one response with both wheel speeds, the nearest
// index, the done flag and the wrapped heading error.
// A pose scans each waypoint of the search window in the states S_SCAN,
// S_DIFF, S_SQX, S_SQY and S_CMP through one memory read port and one shared
// 32x32 multiplier, then runs a 13-step CORDIC, up to two wrap steps and,
// when steering, the iterative divider. A pose after the path is finished
// goes straight to the response with the done flag set.
// req_stall is high while a pose is in progress. A finished response sits in
// the output register; the next request is taken while it waits, and the
// sequencer only holds when a new response is ready and rsp_stall keeps the
// previous one in place. Reset clears the finished flag, the last nearest
// index and the registers to their defaults; the path memory is not cleared
// and every waypoint in use must be written before poses are sent.
// ----------------------------------------------------------------------------
module waypoint_heading_tracker_top #(
   parameter int MAX_POINTS    = wht_pkg::MAX_POINTS_DEF,
   parameter int SEARCH_WINDOW = wht_pkg::SEARCH_WINDOW_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [7:0]         req_point_index,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_heading,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_left_speed,
   output logic [15:0]        rsp_right_speed,
   output logic [7:0]         rsp_nearest_index,
   output logic               rsp_path_done,
   output logic signed [14:0] rsp_heading_error
);

   localparam int AW  = $clog2(MAX_POINTS);
   localparam int CAP = (MAX_POINTS < 256) ? MAX_POINTS : 256;

   wht_pkg::state_type state_ff, state_in;

   logic [15:0]        target_speed_ff;
   logic [13:0]        angle_tol_ff;
   logic [8:0]         point_count_ff;
   logic signed [31:0] px_ff, px_in;
   logic signed [31:0] py_ff, py_in;
   logic signed [15:0] hd_ff, hd_in;
   logic [9:0]         idx_ff, idx_in;
   logic [9:0]         hi_ff, hi_in;
   logic [9:0]         nearest_ff, nearest_in;
   logic               have_best_ff, have_best_in;
   logic [64:0]        best_ff, best_in;
   logic [7:0]         last_ff, last_in;
   logic               finished_ff, finished_in;
   logic [31:0]        dx_ff, dx_in;
   logic [31:0]        dy_ff, dy_in;
   logic [63:0]        sq_a_ff, sq_a_in;
   logic [63:0]        sq_b_ff, sq_b_in;
   logic [63:0]        wa_ff, wa_in;
   logic signed [17:0] err_ff, err_in;
   logic               steer_ff, steer_in;
   logic               done_ff, done_in;
   logic [29:0]        num_ff, num_in;
   logic [21:0]        den_ff, den_in;
   logic [15:0]        slow_ff, slow_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_left_ff, rsp_left_in;
   logic [15:0]        rsp_right_ff, rsp_right_in;
   logic [7:0]         rsp_index_ff, rsp_index_in;
   logic               rsp_done_ff, rsp_done_in;
   logic signed [14:0] rsp_err_ff, rsp_err_in;

   logic               req_take;
   logic               mem_we;
   logic [AW-1:0]      rd_addr;
   logic [63:0]        rd_data;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;
   logic [8:0]         count9;
   logic [9:0]         count10, last10, win10, lo10, hi10;
   logic signed [32:0] diff_x, diff_y;
   logic [64:0]        dist_sum;
   logic [13:0]        err_abs;
   logic               cord_start, cord_done;
   logic signed [32:0] cord_x, cord_y;
   logic signed [15:0] cord_z;
   logic               div_start, div_done;
   logic [29:0]        div_q;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != wht_pkg::S_IDLE);
   assign mem_we = req_take && (req_cmd == wht_pkg::CMD_LOAD) &&
                   (32'(req_point_index) < MAX_POINTS);

   wht_path_mem #(.MAX_POINTS(MAX_POINTS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(req_point_index)),
      .wr_data ({req_pos_y, req_pos_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wht_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .vec_x (cord_x),
      .vec_y (cord_y),
      .done  (cord_done),
      .angle (cord_z)
   );

   wht_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign mul_p = mul_a * mul_b;

   assign count9  = (point_count_ff > 9'(CAP)) ? 9'(CAP) : point_count_ff;
   assign count10 = {1'b0, count9};
   assign last10  = {2'b00, last_ff};
   assign win10   = 10'(SEARCH_WINDOW);
   assign lo10    = (last10 >= win10) ? (last10 - win10) : 10'd0;
   assign hi10    = ((last10 + win10) > count10) ? count10 : (last10 + win10);

   assign diff_x = 33'(signed'(rd_data[31:0])) - 33'(px_ff);
   assign diff_y = 33'(signed'(rd_data[63:32])) - 33'(py_ff);
   assign dist_sum = {1'b0, sq_a_ff} + {1'b0, sq_b_ff};
   assign err_abs = err_ff[17] ? 14'(-err_ff) : 14'(err_ff);

   assign cord_x = 33'(signed'(rd_data[31:0])) - 33'(signed'(wa_ff[31:0]));
   assign cord_y = 33'(signed'(rd_data[63:32])) - 33'(signed'(wa_ff[63:32]));

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      hd_in        = hd_ff;
      idx_in       = idx_ff;
      hi_in        = hi_ff;
      nearest_in   = nearest_ff;
      have_best_in = have_best_ff;
      best_in      = best_ff;
      last_in      = last_ff;
      finished_in  = finished_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sq_a_in      = sq_a_ff;
      sq_b_in      = sq_b_ff;
      wa_in        = wa_ff;
      err_in       = err_ff;
      steer_in     = steer_ff;
      done_in      = done_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      slow_in      = slow_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_index_in = rsp_index_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_err_in   = rsp_err_ff;
      rd_addr      = AW'(idx_ff);
      mul_a        = dx_ff;
      mul_b        = dx_ff;
      cord_start   = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         wht_pkg::S_IDLE: begin
            if (req_take && req_cmd == wht_pkg::CMD_POSE) begin
               px_in = req_pos_x;
               py_in = req_pos_y;
               hd_in = req_heading;
               if (finished_ff) begin
                  done_in  = 1'b1;
                  state_in = wht_pkg::S_EMIT;
               end else begin
                  done_in      = 1'b0;
                  idx_in       = lo10;
                  hi_in        = hi10;
                  nearest_in   = last10;
                  have_best_in = 1'b0;
                  state_in     = wht_pkg::S_SCAN;
               end
            end
         end
         wht_pkg::S_SCAN: begin
            rd_addr  = AW'(idx_ff);
            state_in = (idx_ff < hi_ff) ? wht_pkg::S_DIFF : wht_pkg::S_CHECK;
         end
         wht_pkg::S_DIFF: begin
            dx_in    = diff_x[32] ? 32'(-diff_x) : 32'(diff_x);
            dy_in    = diff_y[32] ? 32'(-diff_y) : 32'(diff_y);
            state_in = wht_pkg::S_SQX;
         end
         wht_pkg::S_SQX: begin
            mul_a    = dx_ff;
            mul_b    = dx_ff;
            sq_a_in  = mul_p;
            state_in = wht_pkg::S_SQY;
         end
         wht_pkg::S_SQY: begin
            mul_a    = dy_ff;
            mul_b    = dy_ff;
            sq_b_in  = mul_p;
            state_in = wht_pkg::S_CMP;
         end
         wht_pkg::S_CMP: begin
            if (!have_best_ff || dist_sum < best_ff) begin
               have_best_in = 1'b1;
               best_in      = dist_sum;
               nearest_in   = idx_ff;
            end
            idx_in   = idx_ff + 10'd1;
            state_in = wht_pkg::S_SCAN;
         end
         wht_pkg::S_CHECK: begin
            last_in = nearest_ff[7:0];
            rd_addr = AW'(nearest_ff);
            if ((nearest_ff + 10'(wht_pkg::LOOKAHEAD)) >= count10) begin
               finished_in = 1'b1;
               done_in     = 1'b1;
               state_in    = wht_pkg::S_EMIT;
            end else begin
               state_in = wht_pkg::S_RDA;
            end
         end
         wht_pkg::S_RDA: begin
            wa_in    = rd_data;
            rd_addr  = AW'(nearest_ff + 10'(wht_pkg::LOOKAHEAD));
            state_in = wht_pkg::S_RDB;
         end
         wht_pkg::S_RDB: begin
            cord_start = 1'b1;
            state_in   = wht_pkg::S_CORD;
         end
         wht_pkg::S_CORD: begin
            if (cord_done) begin
               err_in   = 18'(cord_z) - 18'(hd_ff);
               state_in = wht_pkg::S_WRAP;
            end
         end
         wht_pkg::S_WRAP: begin
            if (err_ff > 18'sd12868) begin
               err_in = err_ff - 18'(wht_pkg::TWO_PI_Q12);
            end else if (err_ff < -18'sd12868) begin
               err_in = err_ff + 18'(wht_pkg::TWO_PI_Q12);
            end else begin
               state_in = wht_pkg::S_SPEED;
            end
         end
         wht_pkg::S_SPEED: begin
            steer_in = (err_abs >= angle_tol_ff);
            state_in = (err_abs >= angle_tol_ff) ? wht_pkg::S_NUM : wht_pkg::S_EMIT;
         end
         wht_pkg::S_NUM: begin
            mul_a    = 32'(target_speed_ff);
            mul_b    = 32'(wht_pkg::PI_Q12);
            num_in   = mul_p[29:0];
            state_in = wht_pkg::S_DEN;
         end
         wht_pkg::S_DEN: begin
            mul_a    = 32'(err_abs);
            mul_b    = 32'(wht_pkg::DEG_HALF);
            den_in   = mul_p[21:0];
            state_in = wht_pkg::S_DIVS;
         end
         wht_pkg::S_DIVS: begin
            if (num_ff == 30'd0) begin
               slow_in  = 16'd0;
               state_in = wht_pkg::S_EMIT;
            end else if (den_ff == 22'd0) begin
               slow_in  = 16'hFFFF;
               state_in = wht_pkg::S_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = wht_pkg::S_DIV;
            end
         end
         wht_pkg::S_DIV: begin
            if (div_done) begin
               slow_in  = (div_q > 30'd65535) ? 16'hFFFF : div_q[15:0];
               state_in = wht_pkg::S_EMIT;
            end
         end
         wht_pkg::S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = last_ff;
               rsp_done_in  = done_ff;
               if (done_ff) begin
                  rsp_left_in  = 16'd0;
                  rsp_right_in = 16'd0;
                  rsp_err_in   = 15'sd0;
               end else begin
                  rsp_left_in  = (steer_ff && !err_ff[17]) ? slow_ff : target_speed_ff;
                  rsp_right_in = (steer_ff && err_ff[17]) ? slow_ff : target_speed_ff;
                  rsp_err_in   = err_ff[14:0];
               end
               state_in = wht_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = wht_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= wht_pkg::S_IDLE;
         last_ff         <= 8'd0;
         finished_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         target_speed_ff <= 16'd16384;
         angle_tol_ff    <= 14'd410;
         point_count_ff  <= 9'd256;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               wht_pkg::CSR_TARGET_SPEED: target_speed_ff <= csr_wdata;
               wht_pkg::CSR_ANGLE_TOL:    angle_tol_ff    <= csr_wdata[13:0];
               wht_pkg::CSR_POINT_COUNT:  point_count_ff  <= csr_wdata[8:0];
               default: begin
               end
            endcase
         end
      end
      px_ff        <= px_in;
      py_ff        <= py_in;
      hd_ff        <= hd_in;
      idx_ff       <= idx_in;
      hi_ff        <= hi_in;
      nearest_ff   <= nearest_in;
      have_best_ff <= have_best_in;
      best_ff      <= best_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sq_a_ff      <= sq_a_in;
      sq_b_ff      <= sq_b_in;
      wa_ff        <= wa_in;
      err_ff       <= err_in;
      steer_ff     <= steer_in;
      done_ff      <= done_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      slow_ff      <= slow_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_index_ff <= rsp_index_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_speed    = rsp_left_ff;
   assign rsp_right_speed   = rsp_right_ff;
   assign rsp_nearest_index = rsp_index_ff;
   assign rsp_path_done     = rsp_done_ff;
   assign rsp_heading_error = rsp_err_ff;

endmodule
